[rtl/wsw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wsw_pkg;

  // field and state widths
  localparam int AddrW    = 32;
  localparam int PageW    = 21;
  localparam int WinW     = 11;
  localparam int PosW     = 10;
  localparam int CntW     = 32;
  localparam int TagW     = 32;

  // tag store
  localparam int MaxWindow = 1024;
  localparam int TagAw     = $clog2(MaxWindow);

  // serial divider
  localparam int DivSteps = AddrW;
  localparam int DivCntW  = $clog2(DivSteps);

  // configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = PageW;

  localparam logic [CfgIdxW-1:0] REG_PAGE_SIZE   = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_SIZE = 1'b1;

  localparam logic [PageW-1:0] PageSizeReset   = 21'd4096;
  localparam logic [WinW-1:0]  WindowSizeReset = 11'd1024;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_EMIT_WIN,
    ST_SCAN,
    ST_APPEND,
    ST_EMIT_END
  } state_t;

endpackage

`default_nettype wire

[rtl/wsw_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module wsw_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [wsw_pkg::AddrW-1:0]     dividend,
  input  wire logic [wsw_pkg::PageW-1:0]     divisor,
  output logic                               done,
  output logic [wsw_pkg::AddrW-1:0]          quotient
);

  logic                          busy;
  logic [wsw_pkg::DivCntW-1:0]   count;
  logic [wsw_pkg::PageW-1:0]     rem;
  logic [wsw_pkg::PageW-1:0]     dvs;
  logic [wsw_pkg::AddrW-1:0]     quo;

  logic [wsw_pkg::PageW:0]       rem_sh;
  logic [wsw_pkg::PageW:0]       diff;
  logic                          ge;

  assign rem_sh   = {rem, quo[wsw_pkg::AddrW-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign ge       = (rem_sh >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= '0;
        dvs   <= divisor;
        quo   <= dividend;
      end else if (busy) begin
        // remainder stays below the divisor, so the low bits hold it
        rem   <= ge ? diff[wsw_pkg::PageW-1:0] : rem_sh[wsw_pkg::PageW-1:0];
        quo   <= {quo[wsw_pkg::AddrW-2:0], ge};
        count <= count + 1'b1;
        if (count == wsw_pkg::DivCntW'(wsw_pkg::DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/working_set_window_counter.sv]
`timescale 1ns / 1ps
`default_nettype none

// Working set monitor. Each input item is one reference address; its page number is
// address divided by the page size in bytes (a page size of 0 acts as 1). References
// fall, in arrival order, into windows of a set number of references (0 acts as 1,
// anything above 1024 acts as 1024). When a reference starts a new window the finished
// window is reported first; a reference with trace_end set reports its own window with
// final_report high and then clears all window state and counters (the config
// registers keep their values). One item can therefore give two result items. An item
// takes longer for each stored tag compared and for each report, and longer still while
// a report waits on out_ready: the page number comes from a one-bit-per-cycle divider,
// and the distinct pages of the window sit in a 1024 x 32 tag memory that is scanned
// one entry per cycle. The longest time from one accept to the next is for a trace_end
// reference that misses against 1023 stored pages. Items are worked on one at a time; a
// finished result waits in the output register while the next item is taken. The tag
// memory needs no clearing: only entries below the fill count are ever read. Config
// writes (cfg_index 0 = page size in bytes, 1 = window length in references) are always
// taken and must only be issued while the block is idle.
module working_set_window_counter (
  input  wire logic                             clk,
  input  wire logic                             rst,

  // reference items
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [wsw_pkg::AddrW-1:0]        address,
  input  wire logic                             trace_end,

  // window reports
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [wsw_pkg::CntW-1:0]              window_index,
  output logic [wsw_pkg::WinW-1:0]              distinct_pages,
  output logic [wsw_pkg::CntW-1:0]              total_distinct,
  output logic [wsw_pkg::CntW-1:0]              windows_reported,
  output logic                                  final_report,

  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [wsw_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [wsw_pkg::CfgDataW-1:0]     cfg_data
);

  // config registers
  logic [wsw_pkg::PageW-1:0]  page_bytes;
  logic [wsw_pkg::WinW-1:0]   window_refs;

  // item being worked on
  logic                       end_q;
  logic [wsw_pkg::TagW-1:0]   page;

  // window state
  logic [wsw_pkg::WinW-1:0]   tags_used;
  logic [wsw_pkg::PosW-1:0]   pos;
  logic [wsw_pkg::CntW-1:0]   cur_win;
  logic [wsw_pkg::CntW-1:0]   run_total;
  logic                       seen_any;

  // tag scan
  logic [wsw_pkg::WinW-1:0]   issue_idx;
  logic                       rd_pending;
  logic [wsw_pkg::TagW-1:0]   rd_data;
  logic [wsw_pkg::TagW-1:0]   tags [wsw_pkg::MaxWindow];

  wsw_pkg::state_t            state;
  wsw_pkg::state_t            state_next;

  // divider hookup
  logic                       div_start;
  logic                       div_done;
  logic [wsw_pkg::AddrW-1:0]  div_quotient;
  logic [wsw_pkg::PageW-1:0]  divisor;

  // control strobes
  logic                       rd_en;
  logic                       mem_we;
  logic                       load_win;
  logic                       load_end;

  // datapath conditions
  logic [wsw_pkg::WinW-1:0]   eff_win;
  logic                       boundary;
  logic                       out_free;
  logic                       more_to_read;
  logic                       hit;
  logic                       scan_miss;
  logic                       room;
  logic [wsw_pkg::CntW:0]     sum;
  logic [wsw_pkg::CntW-1:0]   total_sat;
  logic [wsw_pkg::CntW-1:0]   reported_sat;
  logic                       win_at_max;

  assign cfg_ready = 1'b1;

  // a zero page size divides by one
  assign divisor = (page_bytes == '0) ? wsw_pkg::PageW'(1) : page_bytes;

  wsw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (address),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // effective window length, clamped to 1..MaxWindow
  always_comb begin
    if (window_refs == '0) begin
      eff_win = wsw_pkg::WinW'(1);
    end else if (window_refs > wsw_pkg::WinW'(wsw_pkg::MaxWindow)) begin
      eff_win = wsw_pkg::WinW'(wsw_pkg::MaxWindow);
    end else begin
      eff_win = window_refs;
    end
  end

  // the incoming reference would overflow the current window
  assign boundary = seen_any && (({1'b0, pos} + wsw_pkg::WinW'(1)) >= eff_win);

  assign out_free     = !out_valid || out_ready;
  assign more_to_read = (issue_idx < tags_used);
  assign hit          = rd_pending && (rd_data == page);
  assign scan_miss    = !rd_pending && !more_to_read;
  assign room         = (tags_used < wsw_pkg::WinW'(wsw_pkg::MaxWindow));

  // report arithmetic, all saturating at all ones
  assign sum          = {1'b0, run_total} + (wsw_pkg::CntW+1)'(tags_used);
  assign total_sat    = sum[wsw_pkg::CntW] ? '1 : sum[wsw_pkg::CntW-1:0];
  assign win_at_max   = (cur_win == '1);
  assign reported_sat = win_at_max ? '1 : cur_win + 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wsw_pkg::ST_IDLE: begin
        if (in_valid) state_next = wsw_pkg::ST_DIV;
      end
      wsw_pkg::ST_DIV: begin
        if (div_done) state_next = wsw_pkg::ST_CHECK;
      end
      wsw_pkg::ST_CHECK: begin
        state_next = boundary ? wsw_pkg::ST_EMIT_WIN : wsw_pkg::ST_SCAN;
      end
      wsw_pkg::ST_EMIT_WIN: begin
        if (out_free) state_next = wsw_pkg::ST_SCAN;
      end
      wsw_pkg::ST_SCAN: begin
        if (hit) begin
          state_next = end_q ? wsw_pkg::ST_EMIT_END : wsw_pkg::ST_IDLE;
        end else if (scan_miss) begin
          state_next = wsw_pkg::ST_APPEND;
        end
      end
      wsw_pkg::ST_APPEND: begin
        state_next = end_q ? wsw_pkg::ST_EMIT_END : wsw_pkg::ST_IDLE;
      end
      wsw_pkg::ST_EMIT_END: begin
        if (out_free) state_next = wsw_pkg::ST_IDLE;
      end
      default: state_next = wsw_pkg::ST_IDLE;
    endcase
  end

  // control strobes per state
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    load_win  = 1'b0;
    load_end  = 1'b0;
    case (state)
      wsw_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_valid;
      end
      wsw_pkg::ST_EMIT_WIN: begin
        load_win = out_free;
      end
      wsw_pkg::ST_SCAN: begin
        // keep issuing until a hit shows up; a stray read past it is harmless
        rd_en = more_to_read && !hit;
      end
      wsw_pkg::ST_APPEND: begin
        mem_we = room;
      end
      wsw_pkg::ST_EMIT_END: begin
        load_end = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wsw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_bytes  <= wsw_pkg::PageSizeReset;
      window_refs <= wsw_pkg::WindowSizeReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wsw_pkg::REG_PAGE_SIZE:   page_bytes  <= cfg_data;
        wsw_pkg::REG_WINDOW_SIZE: window_refs <= cfg_data[wsw_pkg::WinW-1:0];
        default: begin
        end
      endcase
    end
  end

  // tag memory: one port, registered read; writes only happen in the append
  // state after the scan has drained, so a read never meets a pending write
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tags[tags_used[wsw_pkg::TagAw-1:0]] <= page;
    end
    if (rd_en) begin
      rd_data <= tags[issue_idx[wsw_pkg::TagAw-1:0]];
    end
  end

  // item payload held for the whole item
  always_ff @(posedge clk) begin
    if (div_start) begin
      end_q <= trace_end;
    end
    if (div_done) begin
      page <= div_quotient;
    end
  end

  // window state and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      tags_used  <= '0;
      pos        <= '0;
      cur_win    <= '0;
      run_total  <= '0;
      seen_any   <= 1'b0;
      issue_idx  <= '0;
      rd_pending <= 1'b0;
    end else begin
      case (state)
        wsw_pkg::ST_CHECK: begin
          issue_idx  <= '0;
          rd_pending <= 1'b0;
          if (!boundary) begin
            // count the reference into the current window
            pos      <= seen_any ? pos + 1'b1 : '0;
            seen_any <= 1'b1;
          end
        end
        wsw_pkg::ST_EMIT_WIN: begin
          if (load_win) begin
            // close the window and start a new one with this reference
            run_total <= total_sat;
            cur_win   <= win_at_max ? cur_win : cur_win + 1'b1;
            tags_used <= '0;
            pos       <= '0;
            seen_any  <= 1'b1;
          end
        end
        wsw_pkg::ST_SCAN: begin
          rd_pending <= rd_en;
          if (rd_en) begin
            issue_idx <= issue_idx + 1'b1;
          end
        end
        wsw_pkg::ST_APPEND: begin
          if (mem_we) begin
            tags_used <= tags_used + 1'b1;
          end
        end
        wsw_pkg::ST_EMIT_END: begin
          if (load_end) begin
            // trace over: back to the reset picture
            tags_used <= '0;
            pos       <= '0;
            seen_any  <= 1'b0;
            cur_win   <= '0;
            run_total <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_win || load_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_win || load_end) begin
      window_index     <= cur_win;
      distinct_pages   <= tags_used;
      total_distinct   <= total_sat;
      windows_reported <= reported_sat;
      final_report     <= load_end;
    end
  end

endmodule

`default_nettype wire

[rtl/wsw_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module wsw_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [wsw_pkg::CntW-1:0]      window_index,
  input  wire logic [wsw_pkg::WinW-1:0]      distinct_pages,
  input  wire logic [wsw_pkg::CntW-1:0]      total_distinct,
  input  wire logic [wsw_pkg::CntW-1:0]      windows_reported
);

  // a stalled report holds its window index and running total
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(window_index)
      && $stable(total_distinct))
    else $error("report changed while stalled");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // count of windows is the index plus one, saturating
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (windows_reported == window_index + 32'd1)
      || (window_index == '1 && windows_reported == '1))
    else $error("windows_reported does not follow window_index");

  // running total includes this window and a window holds at most MaxWindow pages
  a_total: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> total_distinct >= wsw_pkg::CntW'(distinct_pages)
      && distinct_pages <= wsw_pkg::WinW'(wsw_pkg::MaxWindow))
    else $error("distinct page count out of range");

endmodule

bind working_set_window_counter wsw_checker u_wsw_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .window_index     (window_index),
  .distinct_pages   (distinct_pages),
  .total_distinct   (total_distinct),
  .windows_reported (windows_reported)
);

`default_nettype wire
